### rtl/core/mfr_pkg.sv
`timescale 1ns / 1ps

package mfr_pkg;

   // Largest message in bytes; a payload byte at this position or beyond is an overflow.
   localparam int MESSAGE_CAPACITY = 16384;
   localparam int WIDX_W = $clog2(MESSAGE_CAPACITY + 1);

   // Result kinds.
   localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
   localparam logic [1:0] KIND_COMPLETE = 2'd1;
   localparam logic [1:0] KIND_SEQ_ERR  = 2'd2;
   localparam logic [1:0] KIND_OVERFLOW = 2'd3;

   // Header classes, taken from the two top bits of the header byte.
   localparam logic [1:0] HDR_FIRST  = 2'b00;
   localparam logic [1:0] HDR_MIDDLE = 2'b01;
   localparam logic [1:0] HDR_SKIP   = 2'b10;
   localparam logic [1:0] HDR_LAST   = 2'b11;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_MULTICAST_PORT = 1'b0;
   localparam logic [7:0] MULTICAST_PORT_RESET = 8'd100;

   // Result queue.
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int MAX_RESULTS = 3;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_first;
      logic       frame_last;
      logic [7:0] frame_port;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  out_byte;
      logic [13:0] byte_index;
      logic [7:0]  subset_total;
      logic [5:0]  frames_done;
      logic        last;
   } rsp_type;

   // Results of one request handed from the engine to the queue.
   typedef struct packed {
      logic [1:0]                  count;
      rsp_type [MAX_RESULTS-1:0]   item;
   } push_type;

endpackage

### rtl/core/mfr_csr.sv
`timescale 1ns / 1ps

module mfr_csr
   import mfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [7:0]            multicast_port
);

   logic [7:0] port_ff;
   logic [7:0] port_in;
   logic       wr_hit;

   // Registers are decoded on the word address; the low byte-lane bits are ignored.
   assign wr_hit = csr_psel && csr_penable && csr_pwrite
                   && (csr_paddr[CSR_ADDR_W-1] == REG_MULTICAST_PORT);

   assign port_in = wr_hit ? csr_pwdata[7:0] : port_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         port_ff <= MULTICAST_PORT_RESET;
      end else begin
         port_ff <= port_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_ADDR_W-1] == REG_MULTICAST_PORT) begin
         csr_prdata[7:0] = port_ff;
      end
   end

   assign csr_pready     = 1'b1;
   assign multicast_port = port_ff;

endmodule

### rtl/core/mfr_engine.sv
`timescale 1ns / 1ps

module mfr_engine
   import mfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_payload,
   input  logic [7:0] multicast_port,
   input  logic       space_ok,
   output push_type   push
);

   localparam logic [1:0] MODE_IGNORE = 2'd0;
   localparam logic [1:0] MODE_FIRST  = 2'd1;
   localparam logic [1:0] MODE_MIDDLE = 2'd2;
   localparam logic [1:0] MODE_LAST   = 2'd3;

   function automatic logic [13:0] to_index(input logic [WIDX_W-1:0] w);
      logic [WIDX_W+13:0] t;
      t = {14'd0, w};
      return t[13:0];
   endfunction

   function automatic rsp_type make_rsp(input logic [1:0] k, input logic [7:0] v,
                                        input logic [13:0] idx, input logic [7:0] sc,
                                        input logic [5:0] fs);
      rsp_type r;
      r.kind         = k;
      r.out_byte     = v;
      r.byte_index   = idx;
      r.subset_total = sc;
      r.frames_done  = fs;
      r.last         = 1'b0;
      return r;
   endfunction

   // Input register.
   req_type item_ff;
   logic    valid_ff;
   logic    fire;
   logic    take;

   // Reassembly state.
   logic [5:0]        frames_seen_ff, frames_seen_in;
   logic [5:0]        frames_expected_ff, frames_expected_in;
   logic [7:0]        subset_count_ff, subset_count_in;
   logic [WIDX_W-1:0] write_index_ff, write_index_in;
   logic [1:0]        frame_mode_ff, frame_mode_in;
   logic [1:0]        header_position_ff, header_position_in;
   logic              zero_held_ff, zero_held_in;
   logic              payload_stopped_ff, payload_stopped_in;
   logic              message_ready_ff, message_ready_in;

   logic [1:0]                n;
   rsp_type [MAX_RESULTS-1:0] res;
   logic [7:0]                b;
   logic [5:0]                seq;
   logic                      seq_follows;

   assign fire      = valid_ff && space_ok;
   assign req_ready = !valid_ff || fire;
   assign take      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= 1'b1;
      end else if (fire) begin
         valid_ff <= 1'b0;
      end
   end

   assign b   = item_ff.rx_byte;
   assign seq = b[5:0];

   // One request per pass: state update and up to three results, in model order.
   always_comb begin
      frames_seen_in     = frames_seen_ff;
      frames_expected_in = frames_expected_ff;
      subset_count_in    = subset_count_ff;
      write_index_in     = write_index_ff;
      frame_mode_in      = frame_mode_ff;
      header_position_in = header_position_ff;
      zero_held_in       = zero_held_ff;
      payload_stopped_in = payload_stopped_ff;
      message_ready_in   = message_ready_ff;
      n           = 2'd0;
      res         = '0;
      seq_follows = 1'b0;

      if (item_ff.frame_first) begin
         zero_held_in       = 1'b0;
         payload_stopped_in = 1'b0;
         header_position_in = 2'd0;
         // A finished message that never saw its closing byte is dropped here.
         if (message_ready_ff) begin
            subset_count_in  = '0;
            frames_seen_in   = '0;
            write_index_in   = '0;
            message_ready_in = 1'b0;
         end
         // The sequence check uses the frame count left after any dropped message.
         seq_follows = ({1'b0, seq} == ({1'b0, frames_seen_in} + 7'd1));
         if (item_ff.frame_port != multicast_port) begin
            frame_mode_in = MODE_IGNORE;
         end else begin
            case (b[7:6])
               HDR_FIRST: begin
                  frames_expected_in = (seq == 6'd0) ? 6'd1 : seq;
                  frames_seen_in     = 6'd1;
                  write_index_in     = '0;
                  subset_count_in    = '0;
                  message_ready_in   = (seq == 6'd0);
                  frame_mode_in      = MODE_FIRST;
                  header_position_in = 2'd1;
               end
               HDR_MIDDLE: begin
                  if (seq_follows) begin
                     frames_seen_in     = seq;
                     frame_mode_in      = MODE_MIDDLE;
                     header_position_in = 2'd2;
                  end else begin
                     res[n] = make_rsp(KIND_SEQ_ERR, 8'd0, 14'd0,
                                       subset_count_in, frames_seen_in);
                     n = n + 2'd1;
                     subset_count_in    = '0;
                     frames_seen_in     = '0;
                     write_index_in     = '0;
                     message_ready_in   = 1'b0;
                     frame_mode_in      = MODE_IGNORE;
                     header_position_in = 2'd0;
                     zero_held_in       = 1'b0;
                  end
               end
               HDR_LAST: begin
                  if (seq_follows && (seq == frames_expected_ff)) begin
                     frames_seen_in     = seq;
                     message_ready_in   = 1'b1;
                     frame_mode_in      = MODE_LAST;
                     header_position_in = 2'd2;
                  end else begin
                     res[n] = make_rsp(KIND_SEQ_ERR, 8'd0, 14'd0,
                                       subset_count_in, frames_seen_in);
                     n = n + 2'd1;
                     subset_count_in    = '0;
                     frames_seen_in     = '0;
                     write_index_in     = '0;
                     message_ready_in   = 1'b0;
                     frame_mode_in      = MODE_IGNORE;
                     header_position_in = 2'd0;
                     zero_held_in       = 1'b0;
                  end
               end
               default: begin
                  frame_mode_in = MODE_IGNORE;
               end
            endcase
         end
      end else if (frame_mode_ff != MODE_IGNORE) begin
         if (header_position_ff == 2'd1) begin
            subset_count_in    = b;
            header_position_in = 2'd2;
         end else if (!payload_stopped_ff) begin
            if (zero_held_ff) begin
               zero_held_in = 1'b0;
               if (b == 8'd0) begin
                  payload_stopped_in = 1'b1;
               end else begin
                  // The held zero goes out first, then this byte.
                  if (write_index_in >= WIDX_W'(MESSAGE_CAPACITY)) begin
                     res[n] = make_rsp(KIND_OVERFLOW, 8'd0, 14'd0,
                                       subset_count_in, frames_seen_in);
                     n = n + 2'd1;
                     subset_count_in    = '0;
                     frames_seen_in     = '0;
                     write_index_in     = '0;
                     message_ready_in   = 1'b0;
                     frame_mode_in      = MODE_IGNORE;
                     header_position_in = 2'd0;
                  end else begin
                     res[n] = make_rsp(KIND_PAYLOAD, 8'd0, to_index(write_index_in),
                                       subset_count_in, frames_seen_in);
                     n = n + 2'd1;
                     write_index_in = write_index_in + WIDX_W'(1);
                  end
                  if (frame_mode_in != MODE_IGNORE) begin
                     if (write_index_in >= WIDX_W'(MESSAGE_CAPACITY)) begin
                        res[n] = make_rsp(KIND_OVERFLOW, 8'd0, 14'd0,
                                          subset_count_in, frames_seen_in);
                        n = n + 2'd1;
                        subset_count_in    = '0;
                        frames_seen_in     = '0;
                        write_index_in     = '0;
                        message_ready_in   = 1'b0;
                        frame_mode_in      = MODE_IGNORE;
                        header_position_in = 2'd0;
                     end else begin
                        res[n] = make_rsp(KIND_PAYLOAD, b, to_index(write_index_in),
                                          subset_count_in, frames_seen_in);
                        n = n + 2'd1;
                        write_index_in = write_index_in + WIDX_W'(1);
                     end
                  end
               end
            end else if (b == 8'd0) begin
               zero_held_in = 1'b1;
            end else begin
               if (write_index_in >= WIDX_W'(MESSAGE_CAPACITY)) begin
                  res[n] = make_rsp(KIND_OVERFLOW, 8'd0, 14'd0,
                                    subset_count_in, frames_seen_in);
                  n = n + 2'd1;
                  subset_count_in    = '0;
                  frames_seen_in     = '0;
                  write_index_in     = '0;
                  message_ready_in   = 1'b0;
                  frame_mode_in      = MODE_IGNORE;
                  header_position_in = 2'd0;
                  zero_held_in       = 1'b0;
               end else begin
                  res[n] = make_rsp(KIND_PAYLOAD, b, to_index(write_index_in),
                                    subset_count_in, frames_seen_in);
                  n = n + 2'd1;
                  write_index_in = write_index_in + WIDX_W'(1);
               end
            end
         end
      end

      if (item_ff.frame_last) begin
         if ((frame_mode_in != MODE_IGNORE) && message_ready_in) begin
            res[n] = make_rsp(KIND_COMPLETE, 8'd0, to_index(write_index_in) - 14'd1,
                              subset_count_in, frames_seen_in);
            n = n + 2'd1;
            subset_count_in  = '0;
            frames_seen_in   = '0;
            write_index_in   = '0;
            message_ready_in = 1'b0;
         end
         frame_mode_in      = MODE_IGNORE;
         header_position_in = 2'd0;
         zero_held_in       = 1'b0;
      end

      if (n != 2'd0) begin
         res[n - 2'd1].last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_seen_ff     <= '0;
         frames_expected_ff <= '0;
         subset_count_ff    <= '0;
         write_index_ff     <= '0;
         frame_mode_ff      <= MODE_IGNORE;
         header_position_ff <= '0;
         zero_held_ff       <= 1'b0;
         payload_stopped_ff <= 1'b0;
         message_ready_ff   <= 1'b0;
      end else if (fire) begin
         frames_seen_ff     <= frames_seen_in;
         frames_expected_ff <= frames_expected_in;
         subset_count_ff    <= subset_count_in;
         write_index_ff     <= write_index_in;
         frame_mode_ff      <= frame_mode_in;
         header_position_ff <= header_position_in;
         zero_held_ff       <= zero_held_in;
         payload_stopped_ff <= payload_stopped_in;
         message_ready_ff   <= message_ready_in;
      end
   end

   assign push.count = fire ? n : 2'd0;
   assign push.item  = res;

endmodule

### rtl/core/mfr_rsp_queue.sv
`timescale 1ns / 1ps

module mfr_rsp_queue
   import mfr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     space_ok,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_payload
);

   rsp_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                pop;

   assign pop = rsp_valid && rsp_ready;

   // Room for a full burst is judged on the registered count alone.
   assign space_ok = (count_ff <= (QPTR_W + 1)'(QUEUE_DEPTH - MAX_RESULTS));

   assign wr_ptr_in = wr_ptr_ff + QPTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
   assign count_in  = count_ff + (QPTR_W + 1)'(push.count) - (QPTR_W + 1)'(pop);

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (2'(i) < push.count) begin
            entry_ff[wr_ptr_ff + QPTR_W'(i)] <= push.item[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = entry_ff[rd_ptr_ff];

endmodule

### rtl/core/multicast_fragment_reassembler_top.sv
`timescale 1ns / 1ps

// Channel   Ports                              Direction  Content
// request   req_valid, req_ready, req_payload  in         one received frame byte
// response  rsp_valid, rsp_ready, rsp_payload  out        payload, completion or error
// csr       csr_psel ... csr_pready            in/out     multicast port register
//
// A request is taken into an input register and processed, once the queue has room,
// in a single pass that updates the reassembly state and produces up to three
// responses. These go into an eight-entry response queue that drains one response
// per cycle while rsp_ready is high, so the sustained rate is one request per cycle
// while each request yields at most one response; more are bound by the drain rate.
// Request ready depends only on registered state (input register busy and queue
// fill), so a stalled response side never reaches the request side combinationally.
// Synchronous active-high reset empties the queue and restores the reassembly state
// and the multicast port (100); no clearing pass is needed.

module multicast_fragment_reassembler_top
   import mfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [7:0] multicast_port;
   logic       space_ok;
   push_type   push;

   // Configuration register file.
   mfr_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .multicast_port (multicast_port)
   );

   // Input register, frame parser and message state.
   mfr_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .multicast_port (multicast_port),
      .space_ok       (space_ok),
      .push           (push)
   );

   // Response queue feeding the output channel.
   mfr_rsp_queue u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .space_ok    (space_ok),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
